// ----- src/f32a_pkg.sv -----
package f32a_pkg;

    localparam logic [31:0] NAN_CODE  = 32'h7f80_0001;
    localparam logic [31:0] INF_BITS  = 32'h7f80_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hff;
    localparam logic [7:0]  ALIGN_MAX = 8'd24;

    // special-case result decided in the first stage
    typedef struct packed {
        logic        hit;
        logic [31:0] value;
    } special_t;

endpackage

// ----- src/f32a_lzc.sv -----
module f32a_lzc (
    input  logic [24:0] value,
    output logic [4:0]  digits
);

    // bit length of a 25-bit value, 0 for zero
    always_comb begin
        digits = 5'd0;
        for (int i = 0; i < 25; i++) begin
            if (value[i]) begin
                digits = 5'(i + 1);
            end
        end
    end

endmodule

// ----- src/float32_add.sv -----
// float32_add: single-precision adder on raw bit patterns, four register
// stages deep (decode/compare, align/add, bit length, normalize/round into
// the output register). one operand pair is accepted every cycle while the
// pipeline advances; the whole pipeline stalls as one while the output
// register is full and m_tready is low. the hidden bit is always set, so
// exponent 0 counts as a normal exponent. any nan operand or inf plus
// opposite inf gives 0x7f800001; an exact zero sum gives +0; a 25-bit sum
// rounds half up, else truncation.
module float32_add
    import f32a_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] sum_bits
);

    // pipeline advances when the output register is empty or being drained
    logic advance;
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // ---------------- stage 1: decode, specials, exponent compare
    logic [31:0] op_a, op_b;
    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    special_t    spec;
    logic        a_big;

    assign op_a = s_tdata[31:0];
    assign op_b = s_tdata[63:32];
    assign sa = op_a[31];
    assign sb = op_b[31];
    assign ea = op_a[30:23];
    assign eb = op_b[30:23];
    assign fa = op_a[22:0];
    assign fb = op_b[22:0];
    assign a_big = (ea >= eb);

    always_comb begin
        spec.hit   = 1'b1;
        spec.value = NAN_CODE;
        if ((ea == EXP_MAX && fa != '0) || (eb == EXP_MAX && fb != '0)) begin
            spec.value = NAN_CODE;
        end else if (ea == EXP_MAX) begin
            // opposite infinities make a nan
            if (eb == EXP_MAX && sa != sb) begin
                spec.value = NAN_CODE;
            end else begin
                spec.value = INF_BITS | {sa, 31'd0};
            end
        end else if (eb == EXP_MAX) begin
            spec.value = INF_BITS | {sb, 31'd0};
        end else begin
            spec.hit = 1'b0;
        end
    end

    logic        v1_reg;
    special_t    spec1_reg;
    logic        sa1_reg, sb1_reg, abig1_reg;
    logic [23:0] ma1_reg, mb1_reg;
    logic [7:0]  bige1_reg, diff1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
        end
        if (advance) begin
            spec1_reg <= spec;
            sa1_reg   <= sa;
            sb1_reg   <= sb;
            abig1_reg <= a_big;
            ma1_reg   <= {1'b1, fa};
            mb1_reg   <= {1'b1, fb};
            bige1_reg <= a_big ? ea : eb;
            diff1_reg <= a_big ? (ea - eb) : (eb - ea);
        end
    end

    // ---------------- stage 2: align smaller operand, add or subtract
    logic [23:0] small_sh, ma_al, mb_al;
    logic [24:0] raw_next;
    logic        sr_next;

    always_comb begin
        // beyond 24 places the smaller operand vanishes
        small_sh = (diff1_reg <= ALIGN_MAX)
                 ? ((abig1_reg ? mb1_reg : ma1_reg) >> diff1_reg[4:0]) : '0;
        ma_al = abig1_reg ? ma1_reg : small_sh;
        mb_al = abig1_reg ? small_sh : mb1_reg;
        sr_next = sa1_reg;
        if (sa1_reg == sb1_reg) begin
            raw_next = {1'b0, ma_al} + {1'b0, mb_al};
        end else if (ma_al >= mb_al) begin
            raw_next = {1'b0, ma_al - mb_al};
        end else begin
            raw_next = {1'b0, mb_al - ma_al};
            sr_next  = !sa1_reg;
        end
    end

    logic        v2_reg;
    special_t    spec2_reg;
    logic        sr2_reg;
    logic [24:0] raw2_reg;
    logic [7:0]  bige2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= v1_reg;
        end
        if (advance) begin
            spec2_reg <= spec1_reg;
            sr2_reg   <= sr_next;
            raw2_reg  <= raw_next;
            bige2_reg <= bige1_reg;
        end
    end

    // ---------------- stage 3: bit length of the raw sum
    logic [4:0] digits;

    f32a_lzc u_lzc (
        .value  (raw2_reg),
        .digits (digits)
    );

    logic        v3_reg;
    special_t    spec3_reg;
    logic        sr3_reg;
    logic [24:0] raw3_reg;
    logic [7:0]  bige3_reg;
    logic [4:0]  dig3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (advance) begin
            v3_reg <= v2_reg;
        end
        if (advance) begin
            spec3_reg <= spec2_reg;
            sr3_reg   <= sr2_reg;
            raw3_reg  <= raw2_reg;
            bige3_reg <= bige2_reg;
            dig3_reg  <= digits;
        end
    end

    // ---------------- stage 4: normalize, round, range check
    logic [25:0]       rounded;
    logic [24:0]       mr;
    logic signed [9:0] er;
    logic [31:0]       sum_next;

    always_comb begin
        rounded = {1'b0, raw3_reg} + 26'd1;
        if (dig3_reg == 5'd25) begin
            mr = rounded[25:1];
        end else begin
            mr = raw3_reg << (5'd24 - dig3_reg);
        end
        er = $signed({2'b00, bige3_reg}) + $signed({5'd0, dig3_reg}) - 10'sd24;
        if (spec3_reg.hit) begin
            sum_next = spec3_reg.value;
        end else if (raw3_reg == '0) begin
            sum_next = '0;   // exact cancellation is +0
        end else if (er < 0) begin
            sum_next = {sr3_reg, 31'd0};
        end else if (er >= $signed({2'b00, EXP_MAX})) begin
            sum_next = INF_BITS | {sr3_reg, 31'd0};
        end else begin
            sum_next = {sr3_reg, er[7:0], mr[22:0]};
        end
    end

    logic        out_v_reg;
    logic [31:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (advance) begin
            out_v_reg <= v3_reg;
        end
        if (advance) begin
            sum_reg <= sum_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = sum_reg;

endmodule

// ----- tb/tb_float32_add.sv -----
module tb_float32_add;
    import f32a_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // scoreboard: predicts the sum of each accepted operand pair and holds it until
    // the matching result transaction arrives
    class sum_scoreboard;
        logic [31:0] pending_sums[$];
        int          errors;
        int          checked;

        // hidden bit always set, 25-bit sums round half up, everything else truncates
        function logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b);
            logic        sa, sb, sr;
            logic [7:0]  ea, eb, big_e, diff;
            logic [22:0] fa, fb;
            logic [31:0] ma, mb, raw, mr;
            int          digits, er;
            sa = a[31];
            sb = b[31];
            ea = a[30:23];
            eb = b[30:23];
            fa = a[22:0];
            fb = b[22:0];
            ma = {8'd0, 1'b1, fa};
            mb = {8'd0, 1'b1, fb};
            if ((ea == EXP_MAX && fa != 0) || (eb == EXP_MAX && fb != 0))
                return NAN_CODE;
            if (ea == EXP_MAX) begin
                if (eb == EXP_MAX && sa != sb)
                    return NAN_CODE;
                return INF_BITS | {sa, 31'd0};
            end
            if (eb == EXP_MAX)
                return INF_BITS | {sb, 31'd0};
            if (ea >= eb) begin
                diff = ea - eb;
                mb = (diff <= ALIGN_MAX) ? (mb >> diff) : 32'd0;
                big_e = ea;
            end else begin
                diff = eb - ea;
                ma = (diff <= ALIGN_MAX) ? (ma >> diff) : 32'd0;
                big_e = eb;
            end
            sr = sa;
            if (sa == sb) begin
                raw = ma + mb;
            end else if (ma >= mb) begin
                raw = ma - mb;
            end else begin
                raw = mb - ma;
                sr = ~sr;
            end
            if (raw == 0)
                return 32'd0;
            digits = 0;
            for (int i = 0; i < 32; i++)
                if (raw[i])
                    digits = i + 1;
            if (digits == 25)
                mr = (raw + 1) >> 1;
            else
                mr = raw << (24 - digits);
            er = int'(big_e) + digits - 24;
            if (er < 0)
                return {sr, 31'd0};
            if (er >= int'(EXP_MAX))
                return INF_BITS | {sr, 31'd0};
            return {sr, er[7:0], mr[22:0]};
        endfunction

        function void note_operands(logic [31:0] a, logic [31:0] b);
            pending_sums.push_back(predict_sum(a, b));
        endfunction

        function void check_sum(logic [31:0] got);
            logic [31:0] want;
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            checked++;
            if (got !== want) begin
                $display("%0t: sum_bits mismatch, expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;     // [31:0] operand_a, [63:32] operand_b
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] sum_bits

    sum_scoreboard board;
    int            specials_seen;

    float32_add i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // random operand: half with close exponents so alignment and cancellation are exercised,
    // plus raw patterns, extreme exponents and nan/inf encodings
    function automatic logic [31:0] random_operand(logic [7:0] near_exp);
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(0, 15);
        v = $urandom;
        case (pick)
            0, 1, 2: ;
            3: v[30:23] = 8'hff;
            4: begin
                v[30:23] = 8'hff;
                v[22:0] = 23'd0;
            end
            5: v[30:23] = 8'($urandom_range(0, 3));
            6: v[30:23] = 8'($urandom_range(250, 254));
            7: v[22:0] = $urandom_range(0, 1) ? 23'h7fffff : 23'd0;
            default: begin
                v[30:23] = 8'(near_exp + $urandom_range(0, 30) - 15);
            end
        endcase
        return v;
    endfunction

    // one operand-pair transaction; valid stays high across back-to-back calls
    task automatic send_pair(logic [31:0] a, logic [31:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_operands(a, b);
        if (a[30:23] == EXP_MAX || b[30:23] == EXP_MAX)
            specials_seen++;
    endtask

    task automatic idle_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // receiver: alternating phases of always-ready, random stalls and long stalls
    initial begin
        int phase;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            phase = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60)) begin
                case (phase)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // result monitor: sample after the edge where both handshake signals were high
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_sum(m_tdata);
    end

    initial begin
        logic [31:0] directed[22][2];
        logic [31:0] a, b;
        logic [7:0]  e;
        int          burst, waited;
        board = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: nan, opposite and same-sign infinities, cancellation, rounding,
        // overflow, underflow, exponent zero and wide alignment
        directed = '{
            '{32'h7fc0_0000, 32'h3f80_0000}, '{32'h3f80_0000, 32'hff80_0001},
            '{32'h7f80_0000, 32'hff80_0000}, '{32'hff80_0000, 32'h7f80_0000},
            '{32'h7f80_0000, 32'h7f80_0000}, '{32'hff80_0000, 32'h3f80_0000},
            '{32'h4000_0000, 32'hff80_0000}, '{32'h3f80_0000, 32'hbf80_0000},
            '{32'h0000_0000, 32'h8000_0000}, '{32'h3fff_ffff, 32'h3f80_0001},
            '{32'h3fff_ffff, 32'h3fff_ffff}, '{32'h7f7f_ffff, 32'h7f7f_ffff},
            '{32'hff7f_ffff, 32'hff00_0000}, '{32'h0000_0001, 32'h8000_0000},
            '{32'h0080_0000, 32'h8000_0001}, '{32'h0000_0000, 32'h0000_0000},
            '{32'h4b80_0000, 32'h3f80_0000}, '{32'h4c00_0000, 32'h3f80_0000},
            '{32'h7f00_0000, 32'h0000_0001}, '{32'hffff_ffff, 32'h0000_0000},
            '{32'h3f80_0000, 32'hbf7f_ffff}, '{32'h7fff_ffff, 32'hffff_ffff}
        };
        foreach (directed[i])
            send_pair(directed[i][0], directed[i][1]);

        // pause until the pipeline has drained everything expected so far
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_sums.size() != 0)
            @(posedge aclk);

        for (int n = 0; n < 2000; n += burst) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                e = 8'($urandom);
                a = random_operand(e);
                b = random_operand(e);
                // some pairs are near-exact negations to force heavy cancellation
                if ($urandom_range(0, 9) == 0)
                    b = a ^ {1'b1, 8'd0, 23'($urandom_range(0, 3))};
                send_pair(a, b);
            end
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 12));
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (board.pending_sums.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);

        $display("checked %0d sums, %0d with an infinite or nan operand", board.checked,
                 specials_seen);
        if (board.errors == 0 && board.pending_sums.size() == 0)
            $display("tb_float32_add passed");
        else
            $display("tb_float32_add failed");
        $finish;
    end

    // safety net well above the slowest correct run
    initial begin
        #5ms;
        $display("timeout after %0t", $time);
        $display("tb_float32_add failed");
        $finish;
    end

endmodule
